/* design/iewd_pkg.sv */
// Shared types, constants and codes for the I2C EEPROM emulator with watchdog.
`timescale 1ns / 1ps

package iewd_pkg;

  localparam int PAGE_BYTES  = 16;
  localparam int IDX_W       = $clog2(PAGE_BYTES);
  localparam int ROOM_W      = 5;
  localparam int STORE_DEPTH = 256;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int WD_W        = 25;

  localparam logic [ROOM_W-1:0] ROOM_PAGE  = ROOM_W'(PAGE_BYTES);
  localparam logic [ROOM_W-1:0] ROOM_WRITE = ROOM_W'(3);
  localparam logic [IDX_W-1:0]  IDX_LAST   = IDX_W'(PAGE_BYTES - 1);
  localparam logic [4:0]        USED_ADDR  = 5'd2;

  localparam logic [7:0] RESERVED_BYTE = 8'hEE;
  localparam logic [7:0] ERASED_BYTE   = 8'hFF;

  // Write-enable sequence and write targets.
  localparam logic [15:0] EN_ADDR_HI   = 16'h8000;
  localparam logic [15:0] EN_ADDR_LO   = 16'h8001;
  localparam logic [15:0] EN_DATA_ADDR = 16'h8002;
  localparam logic [15:0] STORE_WR_LO  = 16'h0038;
  localparam logic [15:0] STORE_WR_HI  = 16'h007F;
  localparam logic [15:0] WD_ADDR      = 16'h3000;

  // Read map boundaries.
  localparam logic [15:0] STORE_END  = 16'h00FF;
  localparam logic [15:0] INFO_END   = 16'h013F;
  localparam logic [15:0] WD_END     = 16'h3004;
  localparam logic [15:0] SRAM_LO    = 16'h1000;
  localparam logic [15:0] SRAM_HI    = 16'h14FF;
  localparam logic [15:0] FLASH_LO   = 16'h4000;
  localparam logic [15:0] FLASH_HI   = 16'h7FFF;
  localparam logic [15:0] ENREG_HI   = 16'h8003;
  localparam logic [15:0] INFO_BASE  = 16'h0070;
  localparam logic [15:0] INFO_MASK  = 16'h003F;
  localparam logic [15:0] SRAM_MASK  = 16'h04FF;
  localparam logic [15:0] FLASH_MASK = 16'h3FFF;

  localparam logic [WD_W-1:0] WD_BASE_MS = WD_W'(1000);

  typedef enum logic [3:0] {
    OP_READ_FILL   = 4'd0,
    OP_READ_END    = 4'd1,
    OP_WRITE_START = 4'd2,
    OP_WRITE_ERROR = 4'd3,
    OP_WRITE_STOP  = 4'd4,
    OP_WRITE_FULL  = 4'd5,
    OP_TICK        = 4'd6,
    OP_KICK        = 4'd7,
    OP_STOP        = 4'd8
  } op_t;

  typedef enum logic [2:0] {
    RGN_STORE    = 3'd0,
    RGN_INFO     = 3'd1,
    RGN_SRAM     = 3'd2,
    RGN_FLASH    = 3'd3,
    RGN_WATCHDOG = 3'd4,
    RGN_ENABLE   = 3'd5,
    RGN_RESERVED = 3'd6
  } region_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic        tick;
    logic        kick;
    logic        stop;
    logic        load;
    logic [7:0]  data;
    logic [31:0] elapsed;
  } wd_cmd_t;

  typedef struct packed {
    logic [7:0]      cfg;
    logic [WD_W-1:0] remaining;
    logic            expired;
    logic            core_pulse;
    logic            platform_pulse;
  } wd_stat_t;

  typedef struct packed {
    logic [7:0]  data;
    region_t     region;
    logic [15:0] offset;
  } page_t;

endpackage

/* design/iewd_store.sv */
// Byte store: synchronous RAM with per-entry written bits so unwritten bytes read erased.
`timescale 1ns / 1ps

module iewd_store (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [iewd_pkg::STORE_AW-1:0] wr_addr,
  input  logic [7:0]                    wr_data,
  input  logic                          rd_en,
  input  logic [iewd_pkg::STORE_AW-1:0] rd_addr,
  output logic [7:0]                    rd_data
);

  logic [7:0]                       mem [iewd_pkg::STORE_DEPTH];
  logic [iewd_pkg::STORE_DEPTH-1:0] written;
  logic [7:0]                       rd_raw;
  logic                             rd_hit;

  // Writes and reads never fall in the same cycle, so no bypass is needed.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_hit  <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit <= written[rd_addr];
      end
    end
  end

  assign rd_data = rd_hit ? rd_raw : iewd_pkg::ERASED_BYTE;

endmodule

/* design/iewd_wdog.sv */
// Watchdog: configuration byte and millisecond countdown with expiry detection.
`timescale 1ns / 1ps

module iewd_wdog (
  input  logic                clk,
  input  logic                rst,
  input  iewd_pkg::wd_cmd_t   cmd,
  output iewd_pkg::wd_stat_t  stat
);

  logic [7:0]                cfg;
  logic [7:0]                cfg_next;
  logic [iewd_pkg::WD_W-1:0] remaining;
  logic [iewd_pkg::WD_W-1:0] remaining_next;
  logic [7:0]                load_cfg;
  logic [iewd_pkg::WD_W-1:0] reload_val;
  logic                      expired;
  logic                      core_pulse;
  logic                      platform_pulse;

  // A load keeps an already armed configuration; the reload uses whichever is in force.
  assign load_cfg   = (cfg == 8'h00) ? cmd.data : cfg;
  assign reload_val = iewd_pkg::WD_BASE_MS << (cmd.load ? load_cfg[7:4] : cfg[7:4]);

  always_comb begin
    cfg_next       = cfg;
    remaining_next = remaining;
    expired        = 1'b0;
    core_pulse     = 1'b0;
    platform_pulse = 1'b0;
    if (cmd.load) begin
      cfg_next       = load_cfg;
      remaining_next = reload_val;
    end else if (cmd.kick) begin
      remaining_next = reload_val;
    end else if (cmd.stop) begin
      cfg_next       = 8'h00;
      remaining_next = '0;
    end else if (cmd.tick && (remaining != '0)) begin
      if (32'(remaining) > cmd.elapsed) begin
        remaining_next = remaining - iewd_pkg::WD_W'(cmd.elapsed);
      end else begin
        expired        = 1'b1;
        core_pulse     = cfg[0];
        platform_pulse = !cfg[0] && cfg[1];
        cfg_next       = 8'h00;
        remaining_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg       <= 8'h00;
      remaining <= '0;
    end else begin
      cfg       <= cfg_next;
      remaining <= remaining_next;
    end
  end

  assign stat.cfg            = cfg;
  assign stat.remaining      = remaining;
  assign stat.expired        = expired;
  assign stat.core_pulse     = core_pulse;
  assign stat.platform_pulse = platform_pulse;

endmodule

/* design/iewd_map.sv */
// Page map: resolves region, source offset and byte value for one page position.
`timescale 1ns / 1ps

module iewd_map (
  input  logic [15:0]                addr,
  input  logic [iewd_pkg::IDX_W-1:0] idx,
  input  logic [7:0]                 store_byte,
  input  logic [7:0]                 wd_cfg,
  input  logic [iewd_pkg::WD_W-1:0]  wd_remaining,
  input  logic [15:0]                en_addr,
  input  logic [7:0]                 en_data,
  output iewd_pkg::page_t            page
);

  logic [15:0] i16;
  logic [7:0]  k_wd;
  logic [7:0]  k_en;
  logic [31:0] rem32;

  always_comb begin
    i16   = 16'(idx);
    k_wd  = 8'(addr[2:0]) + 8'(idx);
    k_en  = 8'(addr[1:0]) + 8'(idx);
    rem32 = 32'(wd_remaining);
    page.data   = iewd_pkg::RESERVED_BYTE;
    page.region = iewd_pkg::RGN_RESERVED;
    page.offset = 16'h0000;
    if (addr <= iewd_pkg::STORE_END) begin
      page.region = iewd_pkg::RGN_STORE;
      page.offset = 16'(iewd_pkg::STORE_AW'(addr[7:0] + 8'(idx)));
      page.data   = store_byte;
    end else if (addr <= iewd_pkg::INFO_END) begin
      page.region = iewd_pkg::RGN_INFO;
      page.offset = iewd_pkg::INFO_BASE + (addr & iewd_pkg::INFO_MASK) + i16;
      page.data   = 8'h00;
    end else if (addr >= iewd_pkg::WD_ADDR && addr <= iewd_pkg::WD_END) begin
      // Config byte first, then the remaining count, least significant byte first.
      if (k_wd <= 8'd4) begin
        page.region = iewd_pkg::RGN_WATCHDOG;
        page.offset = 16'(k_wd);
        case (k_wd[2:0])
          3'd0:    page.data = wd_cfg;
          3'd1:    page.data = rem32[7:0];
          3'd2:    page.data = rem32[15:8];
          3'd3:    page.data = rem32[23:16];
          default: page.data = rem32[31:24];
        endcase
      end
    end else if (addr >= iewd_pkg::SRAM_LO && addr <= iewd_pkg::SRAM_HI) begin
      page.region = iewd_pkg::RGN_SRAM;
      page.offset = (addr & iewd_pkg::SRAM_MASK) + i16;
      page.data   = 8'h00;
    end else if (addr >= iewd_pkg::FLASH_LO && addr <= iewd_pkg::FLASH_HI) begin
      page.region = iewd_pkg::RGN_FLASH;
      page.offset = (addr & iewd_pkg::FLASH_MASK) + i16;
      page.data   = 8'h00;
    end else if (addr >= iewd_pkg::EN_ADDR_HI && addr <= iewd_pkg::ENREG_HI) begin
      if (k_en <= 8'd3) begin
        page.region = iewd_pkg::RGN_ENABLE;
        page.offset = 16'(k_en);
        case (k_en[1:0])
          2'd0:    page.data = en_addr[7:0];
          2'd1:    page.data = en_addr[15:8];
          2'd2:    page.data = en_data;
          default: page.data = 8'h00;
        endcase
      end
    end
  end

endmodule

/* design/i2c_eeprom_emulator_with_watchdog_core.sv */
// Top level of the I2C EEPROM emulator with watchdog: sequencer, pointer, enable logic.
`timescale 1ns / 1ps

// Usage: the I2C slave front end sends one request per bus event on the input
// channel (in_valid / in_stall, fields op .. elapsed_ms). The block answers on
// the output channel (out_valid / out_stall) with one result per request, or
// with a page of 16 results for a read fill; the final result carries last.
// Every request except a read fill is registered into the output register at
// acceptance, so its result appears in the cycle after, and the next request
// may be taken while that result is presented unless out_stall holds it. A
// read fill first passes the fetch state, which reads the first store byte
// from the RAM, then emits one page byte per cycle while out_stall is low.
// The store RAM is read one entry ahead of the byte being emitted.
// While a page is in progress, no new request is accepted. When the receiver
// holds out_stall, the output register keeps its result and the page sequencer
// waits, and in_stall is raised for as long as the result cannot move on.
// Reset is synchronous and active high: it clears the pointer, the enable
// registers and the watchdog, and marks every store byte unwritten so that
// it reads as 0xFF; it takes effect at once, with no clearing pass.

module i2c_eeprom_emulator_with_watchdog_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  op,
  input  logic [7:0]  addr_high,
  input  logic [7:0]  addr_low,
  input  logic [7:0]  write_byte,
  input  logic [4:0]  bytes_used,
  input  logic [31:0] elapsed_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        nack,
  output logic [4:0]  byte_room,
  output logic [7:0]  read_byte,
  output logic [2:0]  region,
  output logic [15:0] source_offset,
  output logic        last,
  output logic        wd_expired,
  output logic        core_reset_pulse,
  output logic        platform_reset_pulse
);

  iewd_pkg::state_t state;
  iewd_pkg::state_t state_next;

  logic [iewd_pkg::IDX_W-1:0] cnt;
  logic [15:0]                current_address;
  logic [15:0]                current_address_next;
  logic [15:0]                enable_address;
  logic [15:0]                enable_address_next;
  logic [7:0]                 enable_data;
  logic [7:0]                 enable_data_next;

  logic        slot_free;
  logic        in_acc;
  logic        emit;
  logic        rd_en;
  logic [iewd_pkg::STORE_AW-1:0] rd_addr;
  logic [iewd_pkg::IDX_W-1:0]    rd_idx;
  logic [15:0] waddr;
  logic        st_wr_en;
  logic        wd_load;
  logic        refuse;
  logic [7:0]  store_byte;

  iewd_pkg::wd_cmd_t  wd_cmd;
  iewd_pkg::wd_stat_t wd_stat;
  iewd_pkg::page_t    page;

  // The output register can take a new result when it is empty or being drained.
  assign slot_free = !out_valid || !out_stall;
  assign in_acc    = in_valid && !in_stall;
  assign waddr     = {addr_high, addr_low};

  // Next state of the page sequencer.
  always_comb begin
    state_next = state;
    case (state)
      iewd_pkg::S_IDLE: begin
        if (in_acc && (op == iewd_pkg::OP_READ_FILL)) begin
          state_next = iewd_pkg::S_FETCH;
        end
      end
      iewd_pkg::S_FETCH: begin
        state_next = iewd_pkg::S_EMIT;
      end
      iewd_pkg::S_EMIT: begin
        if (emit && (cnt == iewd_pkg::IDX_LAST)) begin
          state_next = iewd_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = iewd_pkg::S_IDLE;
      end
    endcase
  end

  // Sequencer outputs: input stall, RAM read strobe and page byte emission.
  // In the emit state the RAM is read for the byte after the one leaving now.
  always_comb begin
    in_stall = 1'b1;
    emit     = 1'b0;
    rd_en    = 1'b0;
    rd_idx   = cnt;
    case (state)
      iewd_pkg::S_IDLE: begin
        in_stall = !slot_free;
      end
      iewd_pkg::S_FETCH: begin
        rd_en  = 1'b1;
        rd_idx = '0;
      end
      iewd_pkg::S_EMIT: begin
        emit   = slot_free;
        rd_en  = slot_free && (cnt != iewd_pkg::IDX_LAST);
        rd_idx = cnt + 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign rd_addr = iewd_pkg::STORE_AW'(current_address[7:0] + 8'(rd_idx));

  // Request decode: pointer moves, write-enable sequence and write targets.
  always_comb begin
    current_address_next = current_address;
    enable_address_next  = enable_address;
    enable_data_next     = enable_data;
    st_wr_en             = 1'b0;
    wd_load              = 1'b0;
    refuse               = 1'b0;
    if (in_acc) begin
      case (op)
        iewd_pkg::OP_READ_FILL, iewd_pkg::OP_READ_END: begin
          current_address_next = current_address + 16'(bytes_used);
        end
        iewd_pkg::OP_WRITE_STOP: begin
          if (bytes_used == iewd_pkg::USED_ADDR) begin
            current_address_next = waddr;
          end
        end
        iewd_pkg::OP_WRITE_FULL: begin
          current_address_next = waddr;
          if (waddr == iewd_pkg::EN_ADDR_HI) begin
            enable_address_next = {write_byte, 8'h00};
          end else if (waddr == iewd_pkg::EN_ADDR_LO) begin
            enable_address_next = enable_address | 16'(write_byte);
          end else if (waddr == iewd_pkg::EN_DATA_ADDR) begin
            enable_data_next = write_byte;
          end else if ((waddr == enable_address) && (write_byte == enable_data)) begin
            // An enabled write to any other place is acknowledged but only
            // consumes the enable.
            if ((waddr >= iewd_pkg::STORE_WR_LO) && (waddr <= iewd_pkg::STORE_WR_HI)) begin
              st_wr_en = 1'b1;
            end else if (waddr == iewd_pkg::WD_ADDR) begin
              wd_load = 1'b1;
            end
            enable_address_next = 16'h0000;
            enable_data_next    = 8'h00;
          end else begin
            enable_address_next = 16'h0000;
            enable_data_next    = 8'h00;
            refuse              = 1'b1;
          end
        end
        default: begin
          current_address_next = current_address;
        end
      endcase
    end
  end

  always_comb begin
    wd_cmd.tick    = in_acc && (op == iewd_pkg::OP_TICK);
    wd_cmd.kick    = in_acc && (op == iewd_pkg::OP_KICK);
    wd_cmd.stop    = in_acc && (op == iewd_pkg::OP_STOP);
    wd_cmd.load    = wd_load;
    wd_cmd.data    = write_byte;
    wd_cmd.elapsed = elapsed_ms;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= iewd_pkg::S_IDLE;
      cnt             <= '0;
      current_address <= 16'h0000;
      enable_address  <= 16'h0000;
      enable_data     <= 8'h00;
    end else begin
      state           <= state_next;
      current_address <= current_address_next;
      enable_address  <= enable_address_next;
      enable_data     <= enable_data_next;
      if (state == iewd_pkg::S_FETCH) begin
        cnt <= '0;
      end else if (emit) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  // Output register: a single-result request loads it at acceptance, a page
  // loads it one byte per emit cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit || (in_acc && (op != iewd_pkg::OP_READ_FILL))) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      nack                 <= 1'b0;
      byte_room            <= iewd_pkg::ROOM_PAGE;
      read_byte            <= page.data;
      region               <= page.region;
      source_offset        <= page.offset;
      last                 <= (cnt == iewd_pkg::IDX_LAST);
      wd_expired           <= 1'b0;
      core_reset_pulse     <= 1'b0;
      platform_reset_pulse <= 1'b0;
    end else if (in_acc && (op != iewd_pkg::OP_READ_FILL)) begin
      nack                 <= refuse;
      byte_room            <= (op == iewd_pkg::OP_WRITE_START) ? iewd_pkg::ROOM_WRITE : '0;
      read_byte            <= 8'h00;
      region               <= iewd_pkg::RGN_STORE;
      source_offset        <= 16'h0000;
      last                 <= 1'b1;
      wd_expired           <= wd_stat.expired;
      core_reset_pulse     <= wd_stat.core_pulse;
      platform_reset_pulse <= wd_stat.platform_pulse;
    end
  end

  iewd_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (st_wr_en),
    .wr_addr (iewd_pkg::STORE_AW'(addr_low)),
    .wr_data (write_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (store_byte)
  );

  iewd_wdog u_wdog (
    .clk  (clk),
    .rst  (rst),
    .cmd  (wd_cmd),
    .stat (wd_stat)
  );

  iewd_map u_map (
    .addr         (current_address),
    .idx          (cnt),
    .store_byte   (store_byte),
    .wd_cfg       (wd_stat.cfg),
    .wd_remaining (wd_stat.remaining),
    .en_addr      (enable_address),
    .en_data      (enable_data),
    .page         (page)
  );

endmodule
